>>> rtl/core/vdn_pkg.sv
// vdn_pkg: shared constants, codes and payload types for vector_distance_nearest
// depends on nothing; imported by every module of the block except vdn_ram
`timescale 1ns / 1ps
`default_nettype none

package vdn_pkg;

  localparam int MAX_DIM      = 128;
  localparam int ELEMENT_BITS = 16;
  localparam int MAX_VECTORS  = 1048576;

  localparam int ADDR_W = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int LEN_W  = 8;
  localparam int CNT_W  = (LEN_W > ADDR_W + 1) ? LEN_W : ADDR_W + 1;
  localparam int VAL_W  = 16;
  localparam int DIST_W = 40;
  localparam int IDX_W  = 20;
  localparam int VCNT_W = $clog2(MAX_VECTORS);
  localparam int DIFF_W = ELEMENT_BITS + 1;
  localparam int PROD_W = 2 * DIFF_W;
  localparam int ACC_W  = DIST_W + 1;

  localparam int OUTQ_DEPTH = 8;
  localparam int OQ_PTR_W   = $clog2(OUTQ_DEPTH);
  localparam int OQ_CNT_W   = $clog2(OUTQ_DEPTH + 1);

  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  localparam logic [1:0] METRIC_MANHATTAN = 2'd0;
  localparam logic [1:0] METRIC_CHEB      = 2'd1;
  localparam logic [1:0] METRIC_SQ_L2     = 2'd2;
  localparam logic [1:0] METRIC_NEG_IP    = 2'd3;

  localparam logic OP_QUERY = 1'b0;
  localparam logic OP_DATA  = 1'b1;

  localparam logic REG_METRIC = 1'b0;
  localparam logic REG_LENGTH = 1'b1;

  localparam logic [1:0]       METRIC_RESET = METRIC_MANHATTAN;
  localparam logic [LEN_W-1:0] LENGTH_RESET = 8'd128;

  typedef struct packed {
    logic                    opcode;
    logic signed [VAL_W-1:0] element_value;
    logic                    end_of_set;
  } in_item_t;

  typedef struct packed {
    logic signed [DIST_W-1:0] vector_distance;
    logic [IDX_W-1:0]         vector_index;
    logic [IDX_W-1:0]         best_index;
    logic signed [DIST_W-1:0] best_distance;
    logic                     search_done;
  } out_item_t;

  // dataset element leaving the accept stage
  typedef struct packed {
    logic                           valid;
    logic                           cmp;
    logic                           last;
    logic signed [ELEMENT_BITS-1:0] x;
  } elem_t;

  // completed vector distance
  typedef struct packed {
    logic                     valid;
    logic                     last;
    logic signed [DIST_W-1:0] distance;
  } dist_t;

endpackage

`default_nettype wire

>>> rtl/core/vdn_ram.sv
// vdn_ram: generic single write port, single read port RAM with registered read
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module vdn_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 128
) (
  input  wire                                       clk_i,
  input  wire                                       we_i,
  input  wire [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire [WIDTH-1:0]                           wdata_i,
  input  wire                                       re_i,
  input  wire [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                          rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/vdn_front.sv
// vdn_front: accept stage, query/element position counters and query store
// depends on vdn_pkg and vdn_ram
`timescale 1ns / 1ps
`default_nettype none

module vdn_front import vdn_pkg::*; (
  input  wire                     clk_i,
  input  wire                     rst_ni,
  input  wire                     accept_i,
  input  in_item_t                item_i,
  input  wire [LEN_W-1:0]         length_i,
  output elem_t                   s1_o,
  output logic [ELEMENT_BITS-1:0] query_o
);

  logic [ADDR_W-1:0] qpos_q, qpos_d, epos_q, epos_d, wr_addr, rd_addr;
  logic [CNT_W-1:0] len_eff, wr_next, rd_next;
  logic [ELEMENT_BITS+VAL_W-1:0] raw;
  logic is_data, wr_en, rd_en, done;
  elem_t s1_q, s1_d;

  always_comb begin
    raw = {{ELEMENT_BITS{1'b0}}, item_i.element_value};
    if (length_i == '0) begin
      len_eff = CNT_W'(1);
    end else if (CNT_W'(length_i) > CNT_W'(MAX_DIM)) begin
      len_eff = CNT_W'(MAX_DIM);
    end else begin
      len_eff = CNT_W'(length_i);
    end
    is_data = (item_i.opcode == OP_DATA);
    wr_en = accept_i && !is_data;
    rd_en = accept_i && is_data;

    wr_addr = (CNT_W'(qpos_q) >= len_eff) ? '0 : qpos_q;
    wr_next = CNT_W'(wr_addr) + CNT_W'(1);
    qpos_d = qpos_q;
    if (wr_en) begin
      qpos_d = (wr_next >= len_eff) ? '0 : wr_next[ADDR_W-1:0];
    end

    rd_addr = (CNT_W'(epos_q) >= CNT_W'(MAX_DIM)) ? '0 : epos_q;
    rd_next = CNT_W'(rd_addr) + CNT_W'(1);
    done = (rd_next >= len_eff) || item_i.end_of_set;
    epos_d = epos_q;
    if (rd_en) begin
      epos_d = done ? '0 : rd_next[ADDR_W-1:0];
    end

    s1_d.valid = rd_en;
    s1_d.cmp   = done;
    s1_d.last  = item_i.end_of_set;
    s1_d.x     = raw[ELEMENT_BITS-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      qpos_q <= '0;
      epos_q <= '0;
      s1_q   <= '0;
    end else begin
      qpos_q <= qpos_d;
      epos_q <= epos_d;
      s1_q   <= s1_d;
    end
  end

  vdn_ram #(
    .WIDTH(ELEMENT_BITS),
    .DEPTH(MAX_DIM)
  ) u_query_ram (
    .clk_i  (clk_i),
    .we_i   (wr_en),
    .waddr_i(wr_addr),
    .wdata_i(raw[ELEMENT_BITS-1:0]),
    .re_i   (rd_en),
    .raddr_i(rd_addr),
    .rdata_o(query_o)
  );

  assign s1_o = s1_q;

  // end of set always restarts the element position
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_en && item_i.end_of_set |=> epos_q == '0)
    else $error("element position not cleared at end of set");

endmodule

`default_nettype wire

>>> rtl/core/vdn_datapath.sv
// vdn_datapath: per-element difference/product stage and running distance accumulator
// depends on vdn_pkg
`timescale 1ns / 1ps
`default_nettype none

module vdn_datapath import vdn_pkg::*; (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  elem_t                  s1_i,
  input  wire [ELEMENT_BITS-1:0] query_i,
  input  wire [1:0]              metric_i,
  output logic                   s2_pend_o,
  output dist_t                  s3_o
);

  logic signed [DIFF_W-1:0] xe, qe, diff, ma, mb;
  logic [DIFF_W-1:0] mag, mag_q;
  logic signed [PROD_W-1:0] prod, prod_q;
  logic s2_valid_q, s2_cmp_q, s2_last_q;

  logic signed [ACC_W-1:0] acc, sum_x, mag_x, prod_x;
  logic signed [DIST_W-1:0] sum_q, sum_d, clamped;
  dist_t s3_q, s3_d;

  // stage b: difference, magnitude, product
  always_comb begin
    xe   = DIFF_W'(s1_i.x);
    qe   = DIFF_W'(signed'(query_i));
    diff = xe - qe;
    mag  = diff[DIFF_W-1] ? DIFF_W'(-diff) : diff;
    ma   = (metric_i == METRIC_NEG_IP) ? xe : diff;
    mb   = (metric_i == METRIC_NEG_IP) ? qe : diff;
    prod = ma * mb;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
      s2_cmp_q   <= 1'b0;
      s2_last_q  <= 1'b0;
    end else begin
      s2_valid_q <= s1_i.valid;
      s2_cmp_q   <= s1_i.cmp;
      s2_last_q  <= s1_i.last;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q  <= mag;
    prod_q <= prod;
  end

  // stage c: accumulate with saturation
  always_comb begin
    sum_x  = ACC_W'(sum_q);
    mag_x  = ACC_W'(signed'({1'b0, mag_q}));
    prod_x = ACC_W'(prod_q);
    case (metric_i)
      METRIC_MANHATTAN: acc = sum_x + mag_x;
      METRIC_CHEB:      acc = (mag_x > sum_x) ? mag_x : sum_x;
      METRIC_SQ_L2:     acc = sum_x + prod_x;
      default:          acc = sum_x - prod_x;
    endcase
    if (acc[ACC_W-1] != acc[ACC_W-2]) begin
      clamped = acc[ACC_W-1] ? {1'b1, {(DIST_W-1){1'b0}}} : {1'b0, {(DIST_W-1){1'b1}}};
    end else begin
      clamped = acc[DIST_W-1:0];
    end
    sum_d = sum_q;
    if (s2_valid_q) begin
      sum_d = s2_cmp_q ? '0 : clamped;
    end
    s3_d.valid    = s2_valid_q && s2_cmp_q;
    s3_d.last     = s2_last_q;
    s3_d.distance = clamped;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
      s3_q  <= '0;
    end else begin
      sum_q <= sum_d;
      s3_q  <= s3_d;
    end
  end

  assign s2_pend_o = s2_valid_q && s2_cmp_q;
  assign s3_o      = s3_q;

  // a completed vector leaves a fresh accumulator
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_valid_q && s2_cmp_q |=> sum_q == '0)
    else $error("running sum not cleared after vector");

endmodule

`default_nettype wire

>>> rtl/core/vdn_best.sv
// vdn_best: vector counter and running best tracking, builds result items
// depends on vdn_pkg
`timescale 1ns / 1ps
`default_nettype none

module vdn_best import vdn_pkg::*; (
  input  wire       clk_i,
  input  wire       rst_ni,
  input  dist_t     s3_i,
  output logic      push_o,
  output out_item_t push_item_o
);

  logic [VCNT_W-1:0] vcnt_q, vcnt_d, bidx_q, bidx_d, new_idx;
  logic [VCNT_W:0] vcnt_inc;
  logic signed [DIST_W-1:0] bdist_q, bdist_d, new_dist;
  logic have_q, have_d, better;

  always_comb begin
    better   = !have_q || (s3_i.distance < bdist_q);
    new_idx  = better ? vcnt_q : bidx_q;
    new_dist = better ? s3_i.distance : bdist_q;
    vcnt_inc = {1'b0, vcnt_q} + (VCNT_W + 1)'(1);

    vcnt_d  = vcnt_q;
    bidx_d  = bidx_q;
    bdist_d = bdist_q;
    have_d  = have_q;
    if (s3_i.valid) begin
      if (s3_i.last) begin
        vcnt_d  = '0;
        bidx_d  = '0;
        bdist_d = '0;
        have_d  = 1'b0;
      end else begin
        vcnt_d  = (vcnt_inc >= (VCNT_W + 1)'(MAX_VECTORS)) ? '0 : vcnt_inc[VCNT_W-1:0];
        bidx_d  = new_idx;
        bdist_d = new_dist;
        have_d  = 1'b1;
      end
    end

    push_item_o.vector_distance = s3_i.distance;
    push_item_o.vector_index    = IDX_W'(vcnt_q);
    push_item_o.best_index      = IDX_W'(new_idx);
    push_item_o.best_distance   = new_dist;
    push_item_o.search_done     = s3_i.last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vcnt_q  <= '0;
      bidx_q  <= '0;
      bdist_q <= '0;
      have_q  <= 1'b0;
    end else begin
      vcnt_q  <= vcnt_d;
      bidx_q  <= bidx_d;
      bdist_q <= bdist_d;
      have_q  <= have_d;
    end
  end

  assign push_o = s3_i.valid;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s3_i.valid && s3_i.last |=> vcnt_q == '0 && !have_q)
    else $error("search state not cleared at end of set");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !have_q |-> vcnt_q == '0 && bidx_q == '0)
    else $error("vector counter running without a best");

endmodule

`default_nettype wire

>>> rtl/core/vdn_outq.sv
// vdn_outq: result queue between the search pipeline and the output channel
// depends on vdn_pkg
`timescale 1ns / 1ps
`default_nettype none

module vdn_outq import vdn_pkg::*; (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 push_i,
  input  out_item_t           item_i,
  input  wire                 ready_i,
  output logic                valid_o,
  output out_item_t           item_o,
  output logic [OQ_CNT_W-1:0] count_o
);

  out_item_t mem_q [OUTQ_DEPTH];
  logic [OQ_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [OQ_CNT_W-1:0] count_q;
  logic pop;

  assign valid_o = (count_q != '0);
  assign item_o  = mem_q[rd_ptr_q];
  assign count_o = count_q;
  assign pop     = valid_o && ready_i;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == OQ_PTR_W'(OUTQ_DEPTH - 1)) ? '0 : wr_ptr_q + OQ_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == OQ_PTR_W'(OUTQ_DEPTH - 1)) ? '0 : rd_ptr_q + OQ_PTR_W'(1);
      end
      case ({push_i, pop})
        2'b10:   count_q <= count_q + OQ_CNT_W'(1);
        2'b01:   count_q <= count_q - OQ_CNT_W'(1);
        default: count_q <= count_q;
      endcase
    end
  end

  // admission control must keep a slot for every result in flight
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && count_q == OQ_CNT_W'(OUTQ_DEPTH)))
    else $error("result queue overflow");

endmodule

`default_nettype wire

>>> rtl/core/vector_distance_nearest.sv
// vector_distance_nearest: top level, config registers, admission control
// depends on vdn_pkg, vdn_front, vdn_datapath, vdn_best, vdn_outq
// result path: accept, difference and accumulate registers, then the result queue
// throughput: one element per cycle, held off while queued and in-flight results fill 8 slots
// reset: asynchronous; clears positions, sums, counters, best and queue;
//   metric returns to L1 and length to 128; query store is not cleared
`timescale 1ns / 1ps
`default_nettype none

module vector_distance_nearest import vdn_pkg::*; (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                in_valid_i,
  output logic               in_ready_o,
  input  in_item_t           in_data_i,
  output logic               out_valid_o,
  input  wire                out_ready_i,
  output out_item_t          out_data_o,
  input  wire                psel,
  input  wire                penable,
  input  wire                pwrite,
  input  wire [PADDR_W-1:0]  paddr,
  input  wire [PDATA_W-1:0]  pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  logic [1:0] metric_q;
  logic [LEN_W-1:0] length_q;
  logic cfg_wr, accept, s2_pend, push;
  logic [OQ_CNT_W-1:0] q_count;
  logic [OQ_CNT_W:0] pending;
  elem_t s1;
  dist_t s3;
  out_item_t push_item;
  logic [ELEMENT_BITS-1:0] query;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      metric_q <= METRIC_RESET;
      length_q <= LENGTH_RESET;
    end else if (cfg_wr) begin
      case (paddr[PADDR_W-1])
        REG_METRIC: metric_q <= pwdata[1:0];
        REG_LENGTH: length_q <= pwdata[LEN_W-1:0];
        default:    metric_q <= metric_q;
      endcase
    end
  end

  always_comb begin
    case (paddr[PADDR_W-1])
      REG_METRIC: prdata = PDATA_W'(metric_q);
      REG_LENGTH: prdata = PDATA_W'(length_q);
      default:    prdata = '0;
    endcase
  end

  // count every result that may still land in the queue
  always_comb begin
    pending = (OQ_CNT_W + 1)'(q_count)
            + (OQ_CNT_W + 1)'(s1.valid && s1.cmp)
            + (OQ_CNT_W + 1)'(s2_pend)
            + (OQ_CNT_W + 1)'(s3.valid);
    in_ready_o = (pending < (OQ_CNT_W + 1)'(OUTQ_DEPTH));
  end

  assign accept = in_valid_i && in_ready_o;

  vdn_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .accept_i(accept),
    .item_i  (in_data_i),
    .length_i(length_q),
    .s1_o    (s1),
    .query_o (query)
  );

  vdn_datapath u_datapath (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .s1_i     (s1),
    .query_i  (query),
    .metric_i (metric_q),
    .s2_pend_o(s2_pend),
    .s3_o     (s3)
  );

  vdn_best u_best (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s3_i       (s3),
    .push_o     (push),
    .push_item_o(push_item)
  );

  vdn_outq u_outq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .item_i (push_item),
    .ready_i(out_ready_i),
    .valid_o(out_valid_o),
    .item_o (out_data_o),
    .count_o(q_count)
  );

endmodule

`default_nettype wire
